### sv/mpmtr_pkg.sv
// Package for the MTRR page memory type resolver.
// Holds shared widths, type codes, register indexes and the chain beat types.
// No dependencies.
package mpmtr_pkg;

    localparam int FRAME_W = 40;
    localparam int TYPE_W  = 8;
    localparam int PAGE_W  = 52;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;
    localparam int PAB_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    // Page-granular compare covers address bits 30..51.
    localparam int HI_LSB = 30;
    localparam int HI_W   = PAGE_W - HI_LSB;
    // Frame bit that lines up with address bit 30.
    localparam int FRAME_HI_LSB = HI_LSB - 12;

    // Pages below 64 KB are unspecified.
    localparam logic [PAGE_W-1:0] LOW_LIMIT = PAGE_W'(64'h10000);

    localparam logic [TYPE_W-1:0] TYPE_UC = 8'd0;
    localparam logic [TYPE_W-1:0] TYPE_WC = 8'd1;
    localparam logic [TYPE_W-1:0] TYPE_WT = 8'd4;
    localparam logic [TYPE_W-1:0] TYPE_WP = 8'd5;
    localparam logic [TYPE_W-1:0] TYPE_WB = 8'd6;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SUPPORTED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_TYPE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_CNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAB       = 3'd4;

    // Query beat carried from cell to cell.
    typedef struct packed {
        logic              live;
        logic              done;
        logic              status;
        logic [TYPE_W-1:0] mtype;
        logic              have_cand;
        logic [TYPE_W-1:0] cand;
    } tok_t;

    // Query operands held steady for every cell while a beat walks the chain.
    typedef struct packed {
        logic [HI_W-1:0]  page_hi;
        logic [HI_W-1:0]  hi_mask;
        logic             lo_force;
        logic [CNT_W-1:0] range_count;
    } qry_t;

    function automatic logic type_reserved(input logic [TYPE_W-1:0] t);
        return !(t == TYPE_UC || t == TYPE_WC || t == TYPE_WT ||
                 t == TYPE_WP || t == TYPE_WB);
    endfunction

endpackage

### sv/mtrr_page_memory_type_resolver.sv
// Top level of the MTRR page memory type resolver: config registers,
// command control and the chain of entry cells. Depends on mpmtr_pkg, mpmtr_cell.
//
//  channel   signals                                   direction
//  command   start, busy, opcode, entry_*, page_addr   in (busy out)
//  result    done, mem_type, type_status               out, one-cycle strobe
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in (cfg_ready out)
//
// A load is taken when start meets busy low and leaves no result; busy stays low.
// A query that ends early (low page, MTRRs off) gives its result in the next cycle.
// Otherwise the query beat walks the cell chain, one cell per cycle, through each
// cell's beat register and then the result register; busy is high until the result comes.
// Reset clears all valid bits and loads the config defaults at once; there is
// no result stall.
module mtrr_page_memory_type_resolver #(
    parameter int unsigned MAX_RANGES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              opcode,
    input  logic [mpmtr_pkg::IDX_W-1:0]       entry_index,
    input  logic [mpmtr_pkg::FRAME_W-1:0]     entry_base_frame,
    input  logic [mpmtr_pkg::FRAME_W-1:0]     entry_mask_frame,
    input  logic [mpmtr_pkg::TYPE_W-1:0]      entry_type,
    input  logic                              entry_valid,
    input  logic [mpmtr_pkg::PAGE_W-1:0]      page_addr,
    output logic                              done,
    output logic [mpmtr_pkg::TYPE_W-1:0]      mem_type,
    output logic                              type_status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mpmtr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mpmtr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                          supported_reg;
    logic                          enabled_reg;
    logic [mpmtr_pkg::TYPE_W-1:0]  def_type_reg;
    logic [mpmtr_pkg::CNT_W-1:0]   range_cnt_reg;
    logic [mpmtr_pkg::PAB_W-1:0]   pab_reg;

    logic [mpmtr_pkg::HI_W-1:0]    page_hi_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [mpmtr_pkg::TYPE_W-1:0]  mtype_reg;
    logic                          status_reg;

    logic                          fire;
    logic                          load_fire;
    logic                          query_fire;
    logic                          low_page;
    logic                          mtrr_off;
    logic                          inject;
    mpmtr_pkg::qry_t               qry;
    mpmtr_pkg::tok_t               tok [MAX_RANGES+1];
    mpmtr_pkg::tok_t               tail;

    assign cfg_ready = 1'b1;
    assign busy      = busy_reg;

    assign fire       = start && !busy_reg;
    assign load_fire  = fire && (opcode == mpmtr_pkg::OP_LOAD);
    assign query_fire = fire && (opcode == mpmtr_pkg::OP_QUERY);
    assign low_page   = page_addr < mpmtr_pkg::LOW_LIMIT;
    assign mtrr_off   = !supported_reg || !enabled_reg;
    assign inject     = query_fire && !low_page && !mtrr_off;

    // Write config registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supported_reg <= 1'b1;
            enabled_reg   <= 1'b0;
            def_type_reg  <= '0;
            range_cnt_reg <= 5'd8;
            pab_reg       <= 6'd46;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mpmtr_pkg::CFG_SUPPORTED: supported_reg <= cfg_data[0];
                mpmtr_pkg::CFG_ENABLED:   enabled_reg   <= cfg_data[0];
                mpmtr_pkg::CFG_DEF_TYPE:  def_type_reg  <= cfg_data;
                mpmtr_pkg::CFG_RANGE_CNT: range_cnt_reg <= cfg_data[mpmtr_pkg::CNT_W-1:0];
                mpmtr_pkg::CFG_PAB:       pab_reg       <= cfg_data[mpmtr_pkg::PAB_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the page bits that matter for the whole walk.
    always_ff @(posedge clk)
    begin
        if (inject)
        begin
            page_hi_reg <= page_addr[mpmtr_pkg::PAGE_W-1:mpmtr_pkg::HI_LSB];
        end
    end

    // Feed the first cell straight from the port in the launch cycle.
    // Address bits at or above the physical width count as masked.
    always_comb
    begin
        qry.page_hi     = inject ? page_addr[mpmtr_pkg::PAGE_W-1:mpmtr_pkg::HI_LSB]
                                 : page_hi_reg;
        qry.range_count = range_cnt_reg;
        qry.lo_force    = pab_reg < mpmtr_pkg::PAB_W'(mpmtr_pkg::HI_LSB);
        for (int k = 0; k < mpmtr_pkg::HI_W; k++)
        begin
            qry.hi_mask[k] = mpmtr_pkg::PAB_W'(mpmtr_pkg::HI_LSB + k) >= pab_reg;
        end
    end

    // Launch a fresh beat into the first cell.
    always_comb
    begin
        tok[0]           = '0;
        tok[0].live      = inject;
    end

    // Cell chain, one entry per cell.
    for (genvar i = 0; i < MAX_RANGES; i++)
    begin : g_cell
        mpmtr_cell #(
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .we       (load_fire && ({3'b000, entry_index} == 7'(i))),
            .wr_base  (entry_base_frame),
            .wr_mask  (entry_mask_frame),
            .wr_type  (entry_type),
            .wr_valid (entry_valid),
            .qry      (qry),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    assign tail = tok[MAX_RANGES];

    // Control and result register: early exits or the beat leaving the chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            mtype_reg  <= '0;
            status_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (inject)
            begin
                busy_reg <= 1'b1;
            end
            else if (query_fire)
            begin
                done_reg   <= 1'b1;
                mtype_reg  <= mpmtr_pkg::TYPE_UC;
                status_reg <= low_page;
            end
            if (tail.live)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
                if (tail.done)
                begin
                    mtype_reg  <= tail.mtype;
                    status_reg <= tail.status;
                end
                else if (!tail.have_cand || mpmtr_pkg::type_reserved(tail.cand))
                begin
                    mtype_reg  <= def_type_reg;
                    status_reg <= 1'b0;
                end
                else
                begin
                    mtype_reg  <= tail.cand;
                    status_reg <= 1'b0;
                end
            end
        end
    end

    assign done        = done_reg;
    assign mem_type    = mtype_reg;
    assign type_status = status_reg;

endmodule

### sv/mpmtr_cell.sv
// One variable-range entry of the resolver chain.
// Stores base, mask, type and valid; updates the query beat and passes it on.
// Depends on mpmtr_pkg.
module mpmtr_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          we,
    input  logic [mpmtr_pkg::FRAME_W-1:0] wr_base,
    input  logic [mpmtr_pkg::FRAME_W-1:0] wr_mask,
    input  logic [mpmtr_pkg::TYPE_W-1:0]  wr_type,
    input  logic                          wr_valid,
    input  mpmtr_pkg::qry_t               qry,
    input  mpmtr_pkg::tok_t               tok_in,
    output mpmtr_pkg::tok_t               tok_out
);

    logic [mpmtr_pkg::FRAME_W-1:0] base_reg;
    logic [mpmtr_pkg::FRAME_W-1:0] mask_reg;
    logic [mpmtr_pkg::TYPE_W-1:0]  type_reg;
    logic                          valid_reg;
    mpmtr_pkg::tok_t               tok_reg;
    mpmtr_pkg::tok_t               tok_next;

    logic                          en;
    logic [mpmtr_pkg::HI_W-1:0]    diff;
    logic                          hit;
    logic                          partial;
    logic                          wb_keep;

    // Hold the entry payload; the valid bit alone needs a reset.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            base_reg <= wr_base;
            mask_reg <= wr_mask;
            type_reg <= wr_type;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (we)
        begin
            valid_reg <= wr_valid;
        end
    end

    // Compare the entry against the 1 GB page.
    always_comb
    begin
        en = valid_reg && (7'(IDX) < {2'b00, qry.range_count});
        diff = (base_reg[mpmtr_pkg::FRAME_W-1:mpmtr_pkg::FRAME_HI_LSB] ^ qry.page_hi) &
               (mask_reg[mpmtr_pkg::FRAME_W-1:mpmtr_pkg::FRAME_HI_LSB] | qry.hi_mask);
        hit = (diff == '0);
        partial = (|mask_reg[mpmtr_pkg::FRAME_HI_LSB-1:0]) || qry.lo_force;
        wb_keep = (type_reg == mpmtr_pkg::TYPE_WB) && tok_in.have_cand &&
                  (tok_in.cand == mpmtr_pkg::TYPE_WT || tok_in.cand == mpmtr_pkg::TYPE_WB);
    end

    // Update the beat: finish on partial overlap or UC, else merge the candidate.
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.live && !tok_in.done && en && hit)
        begin
            if (partial)
            begin
                tok_next.done   = 1'b1;
                tok_next.status = 1'b1;
                tok_next.mtype  = mpmtr_pkg::TYPE_UC;
            end
            else if (type_reg == mpmtr_pkg::TYPE_UC)
            begin
                tok_next.done   = 1'b1;
                tok_next.status = 1'b0;
                tok_next.mtype  = mpmtr_pkg::TYPE_UC;
            end
            else if (!wb_keep)
            begin
                tok_next.cand      = type_reg;
                tok_next.have_cand = 1'b1;
            end
        end
    end

    // Advance the beat to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### tb/sv/mtrr_page_memory_type_resolver_test.sv
// Self-checking testbench for mtrr_page_memory_type_resolver: directed and random
// table loads and page queries, with a built-in page type predictor and result check.
// Depends on mpmtr_pkg and the mtrr_page_memory_type_resolver RTL.
module mtrr_page_memory_type_resolver_test;

    localparam int SLOTS = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = SLOTS + 6;
    localparam logic [mpmtr_pkg::FRAME_W-1:0] FRAME_ONES = '1;
    localparam logic [63:0] ABOVE_1G = ~64'h3FFF_FFFF;
    localparam logic [63:0] LOW_PAGE_END = 64'h10000;

    typedef struct packed {
        logic [mpmtr_pkg::TYPE_W-1:0] mtype;
        logic                         status;
    } page_type_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 start;
    logic                                 busy;
    logic                                 opcode;
    logic [mpmtr_pkg::IDX_W-1:0]          entry_index;
    logic [mpmtr_pkg::FRAME_W-1:0]        entry_base_frame;
    logic [mpmtr_pkg::FRAME_W-1:0]        entry_mask_frame;
    logic [mpmtr_pkg::TYPE_W-1:0]         entry_type;
    logic                                 entry_valid;
    logic [mpmtr_pkg::PAGE_W-1:0]         page_addr;
    logic                                 done;
    logic [mpmtr_pkg::TYPE_W-1:0]         mem_type;
    logic                                 type_status;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [mpmtr_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [mpmtr_pkg::CFG_DATA_W-1:0]     cfg_data;

    // Predictor copy of the range table and the registers
    logic [mpmtr_pkg::FRAME_W-1:0] slot_base [SLOTS];
    logic [mpmtr_pkg::FRAME_W-1:0] slot_mask [SLOTS];
    logic [mpmtr_pkg::TYPE_W-1:0]  slot_kind [SLOTS];
    logic                          slot_valid [SLOTS];
    logic                          reg_supported;
    logic                          reg_enabled;
    logic [mpmtr_pkg::TYPE_W-1:0]  reg_default;
    logic [mpmtr_pkg::CNT_W-1:0]   reg_range_count;
    logic [mpmtr_pkg::PAB_W-1:0]   reg_addr_bits;

    page_type_t expected_types [$];
    page_type_t want;
    int         mismatch_count;
    int         idle_cycles;
    int         burst_left;

    mtrr_page_memory_type_resolver #(.MAX_RANGES(SLOTS)) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .entry_index      (entry_index),
        .entry_base_frame (entry_base_frame),
        .entry_mask_frame (entry_mask_frame),
        .entry_type       (entry_type),
        .entry_valid      (entry_valid),
        .page_addr        (page_addr),
        .done             (done),
        .mem_type         (mem_type),
        .type_status      (type_status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit known_type(input logic [mpmtr_pkg::TYPE_W-1:0] t);
        case (t)
            mpmtr_pkg::TYPE_UC, mpmtr_pkg::TYPE_WC, mpmtr_pkg::TYPE_WT,
            mpmtr_pkg::TYPE_WP, mpmtr_pkg::TYPE_WB: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Resolve the memory type of one 1 GB page against the current table
    function automatic page_type_t resolve_page_type(input logic [mpmtr_pkg::PAGE_W-1:0] page);
        page_type_t r;
        logic [63:0] pg;
        logic [63:0] above_width;
        logic [63:0] rb;
        logic [63:0] rm;
        logic [63:0] cmp;
        logic [mpmtr_pkg::TYPE_W-1:0] best;
        logic have;
        int n;
        int i;
        pg = 64'(page);
        r.mtype = mpmtr_pkg::TYPE_UC;
        r.status = 1'b0;
        if (pg < LOW_PAGE_END)
        begin
            r.status = 1'b1;
            return r;
        end
        if (!reg_supported || !reg_enabled)
            return r;
        above_width = ~((64'd1 << reg_addr_bits) - 64'd1);
        n = (int'(reg_range_count) > SLOTS) ? SLOTS : int'(reg_range_count);
        have = 1'b0;
        best = mpmtr_pkg::TYPE_UC;
        for (i = 0; i < n; i++)
        begin
            if (!slot_valid[i])
                continue;
            rb = 64'(slot_base[i]) << 12;
            rm = (64'(slot_mask[i]) << 12) | above_width;
            cmp = rm & ABOVE_1G;
            // skip ranges that miss the page entirely
            if ((rb & cmp) != (pg & cmp))
                continue;
            // a mask finer than 1 GB splits the page
            if (rm[29:0] != '0)
            begin
                r.status = 1'b1;
                return r;
            end
            if (slot_kind[i] == mpmtr_pkg::TYPE_UC)
                return r;
            if (slot_kind[i] == mpmtr_pkg::TYPE_WB && have &&
                (best == mpmtr_pkg::TYPE_WT || best == mpmtr_pkg::TYPE_WB))
                continue;
            best = slot_kind[i];
            have = 1'b1;
        end
        r.mtype = (have && known_type(best)) ? best : reg_default;
        return r;
    endfunction

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_types.size() == 0)
            begin
                $display("%0t: unexpected result: mem_type %0d status %0d",
                         $time, mem_type, type_status);
                mismatch_count++;
            end
            else
            begin
                want = expected_types.pop_front();
                if (mem_type !== want.mtype)
                begin
                    $display("%0t: mem_type expected %0d actual %0d",
                             $time, want.mtype, mem_type);
                    mismatch_count++;
                end
                if (type_status !== want.status)
                begin
                    $display("%0t: type_status expected %0d actual %0d",
                             $time, want.status, type_status);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [mpmtr_pkg::FRAME_W-1:0] gb_frame(input int gb);
        return mpmtr_pkg::FRAME_W'(gb) << mpmtr_pkg::FRAME_HI_LSB;
    endfunction

    // Mask frame for a naturally aligned range of 2**k GB
    function automatic logic [mpmtr_pkg::FRAME_W-1:0] span_mask(input int k);
        return FRAME_ONES & ~((mpmtr_pkg::FRAME_W'(1) << (mpmtr_pkg::FRAME_HI_LSB + k)) -
                              mpmtr_pkg::FRAME_W'(1));
    endfunction

    function automatic logic [mpmtr_pkg::PAGE_W-1:0] gb_page(input int gb);
        return mpmtr_pkg::PAGE_W'(gb) << mpmtr_pkg::HI_LSB;
    endfunction

    // Send one command beat, update the predictor on acceptance, then pace
    task automatic send_cmd(input logic op, input logic [mpmtr_pkg::IDX_W-1:0] idx,
                            input logic [mpmtr_pkg::FRAME_W-1:0] base,
                            input logic [mpmtr_pkg::FRAME_W-1:0] mask,
                            input logic [mpmtr_pkg::TYPE_W-1:0] kind, input logic vld,
                            input logic [mpmtr_pkg::PAGE_W-1:0] page);
        int gap;
        start <= 1'b1;
        opcode <= op;
        entry_index <= idx;
        entry_base_frame <= base;
        entry_mask_frame <= mask;
        entry_type <= kind;
        entry_valid <= vld;
        page_addr <= page;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op == mpmtr_pkg::OP_LOAD)
        begin
            slot_base[idx] = base;
            slot_mask[idx] = mask;
            slot_kind[idx] = kind;
            slot_valid[idx] = vld;
        end
        else
            expected_types.push_back(resolve_page_type(page));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 15);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // Load a slot; the query field carries noise
    task automatic load_slot(input int idx, input logic [mpmtr_pkg::FRAME_W-1:0] base,
                             input logic [mpmtr_pkg::FRAME_W-1:0] mask,
                             input logic [mpmtr_pkg::TYPE_W-1:0] kind,
                             input logic vld);
        send_cmd(mpmtr_pkg::OP_LOAD, mpmtr_pkg::IDX_W'(idx), base, mask, kind, vld,
                 mpmtr_pkg::PAGE_W'({$urandom, $urandom}));
    endtask

    // Query a page; the load fields carry noise
    task automatic query_page(input logic [mpmtr_pkg::PAGE_W-1:0] page);
        send_cmd(mpmtr_pkg::OP_QUERY, mpmtr_pkg::IDX_W'($urandom),
                 mpmtr_pkg::FRAME_W'({$urandom, $urandom}),
                 mpmtr_pkg::FRAME_W'({$urandom, $urandom}), mpmtr_pkg::TYPE_W'($urandom),
                 1'($urandom), page);
    endtask

    // Hold the sender until every result is in and the block has settled
    task automatic drain;
        start <= 1'b0;
        while (expected_types.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register beat; drop valid after the last beat of a group
    task automatic set_register(input logic [mpmtr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [mpmtr_pkg::CFG_DATA_W-1:0] value,
                                input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            mpmtr_pkg::CFG_SUPPORTED: reg_supported = value[0];
            mpmtr_pkg::CFG_ENABLED:   reg_enabled = value[0];
            mpmtr_pkg::CFG_DEF_TYPE:  reg_default = value;
            mpmtr_pkg::CFG_RANGE_CNT: reg_range_count = value[mpmtr_pkg::CNT_W-1:0];
            mpmtr_pkg::CFG_PAB:       reg_addr_bits = value[mpmtr_pkg::PAB_W-1:0];
            default: ;
        endcase
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic reconfigure(input bit sup, input bit en, input int def_type,
                               input int count, input int addr_bits);
        drain();
        set_register(mpmtr_pkg::CFG_SUPPORTED, mpmtr_pkg::CFG_DATA_W'(sup), 1'b0);
        set_register(mpmtr_pkg::CFG_ENABLED, mpmtr_pkg::CFG_DATA_W'(en), 1'b0);
        set_register(mpmtr_pkg::CFG_DEF_TYPE, mpmtr_pkg::CFG_DATA_W'(def_type), 1'b0);
        set_register(mpmtr_pkg::CFG_RANGE_CNT, mpmtr_pkg::CFG_DATA_W'(count), 1'b0);
        set_register(mpmtr_pkg::CFG_PAB, mpmtr_pkg::CFG_DATA_W'(addr_bits), 1'b1);
    endtask

    // Reset values: MTRRs disabled forces UC, low pages stay unspecified
    task automatic check_reset_defaults;
        query_page(gb_page(1));
        query_page(mpmtr_pkg::PAGE_W'(64'hFFFF));
        query_page(mpmtr_pkg::LOW_LIMIT);
    endtask

    // Scan rules with the reset count, width and default
    task automatic check_range_rules;
        drain();
        set_register(mpmtr_pkg::CFG_ENABLED, mpmtr_pkg::CFG_DATA_W'(1), 1'b1);
        load_slot(0, gb_frame(1), span_mask(0), mpmtr_pkg::TYPE_WT, 1'b1);
        load_slot(1, gb_frame(1), span_mask(0), mpmtr_pkg::TYPE_WB, 1'b1);
        load_slot(2, gb_frame(4), span_mask(1), mpmtr_pkg::TYPE_UC, 1'b1);
        load_slot(3, gb_frame(8), span_mask(0) | mpmtr_pkg::FRAME_W'(1),
                  mpmtr_pkg::TYPE_WC, 1'b1);
        load_slot(4, gb_frame(16), span_mask(0), mpmtr_pkg::TYPE_W'(8'h07), 1'b1);
        load_slot(5, gb_frame(2), span_mask(0), mpmtr_pkg::TYPE_WB, 1'b1);
        load_slot(6, gb_frame(2), span_mask(0), mpmtr_pkg::TYPE_WC, 1'b1);
        load_slot(7, gb_frame(3), span_mask(0), mpmtr_pkg::TYPE_UC, 1'b0);
        query_page(gb_page(1));
        query_page(gb_page(5));
        query_page(gb_page(8));
        query_page(gb_page(16));
        query_page(gb_page(2));
        query_page(gb_page(3));
    endtask

    // Register extremes: no ranges, oversized count, reserved default, odd widths, no MTRR support
    task automatic check_register_extremes;
        reconfigure(1'b1, 1'b1, 8'hFF, 0, 36);
        query_page(gb_page(1));
        reconfigure(1'b1, 1'b1, 8'h03, 31, 63);
        load_slot(15, gb_frame(32), span_mask(0), mpmtr_pkg::TYPE_WP, 1'b1);
        query_page(gb_page(32));
        query_page(gb_page(16));
        reconfigure(1'b1, 1'b1, 8'h00, 16, 0);
        query_page(gb_page(1));
        reconfigure(1'b1, 1'b1, 8'h55, 16, 52);
        load_slot(14, FRAME_ONES, FRAME_ONES, 8'hFF, 1'b1);
        query_page('1);
        reconfigure(1'b0, 1'b1, 8'h55, 16, 52);
        query_page(gb_page(1));
    endtask

    // One random beat: mostly aligned ranges and pages, some raw noise
    task automatic random_beat;
        int roll;
        int k;
        int gb;
        logic [mpmtr_pkg::FRAME_W-1:0] mask;
        logic [mpmtr_pkg::TYPE_W-1:0] kind;
        logic [mpmtr_pkg::PAGE_W-1:0] page;
        roll = $urandom_range(0, 99);
        if (roll < 20)
        begin
            send_cmd(1'($urandom), mpmtr_pkg::IDX_W'($urandom),
                     mpmtr_pkg::FRAME_W'({$urandom, $urandom}),
                     mpmtr_pkg::FRAME_W'({$urandom, $urandom}),
                     mpmtr_pkg::TYPE_W'($urandom), 1'($urandom),
                     mpmtr_pkg::PAGE_W'({$urandom, $urandom}));
        end
        else if (roll < 45)
        begin
            k = $urandom_range(0, 3);
            gb = $urandom_range(0, 31) & ~((1 << k) - 1);
            mask = span_mask(k);
            if ($urandom_range(0, 7) == 0)
                mask[$urandom_range(0, mpmtr_pkg::FRAME_HI_LSB - 1)] = 1'b1;
            case ($urandom_range(0, 7))
                0: kind = mpmtr_pkg::TYPE_UC;
                1: kind = mpmtr_pkg::TYPE_WC;
                2, 3: kind = mpmtr_pkg::TYPE_WT;
                4: kind = mpmtr_pkg::TYPE_WP;
                5, 6: kind = mpmtr_pkg::TYPE_WB;
                default: kind = mpmtr_pkg::TYPE_W'($urandom);
            endcase
            load_slot($urandom_range(0, SLOTS - 1), gb_frame(gb), mask, kind,
                      $urandom_range(0, 9) != 0);
        end
        else
        begin
            page = gb_page($urandom_range(0, 31));
            if ($urandom_range(0, 3) == 0)
                page[mpmtr_pkg::HI_LSB-1:0] = mpmtr_pkg::HI_LSB'($urandom);
            if ($urandom_range(0, 19) == 0)
                page = mpmtr_pkg::PAGE_W'($urandom_range(0, 16'hFFFF));
            query_page(page);
        end
    endtask

    // Random traffic over several register settings
    task automatic run_random_traffic;
        int p;
        int beats;
        for (p = 0; p < 7; p++)
        begin
            beats = 260;
            case (p)
                0: reconfigure(1'b1, 1'b1, $urandom_range(0, 255), 16, 36);
                1: reconfigure(1'b1, 1'b1, mpmtr_pkg::TYPE_WB, $urandom_range(0, 16), 52);
                2: reconfigure(1'b1, 1'b1, 255, 31, 63);
                3:
                begin
                    reconfigure(1'b0, 1'b1, $urandom_range(0, 255), 16, 46);
                    beats = 60;
                end
                4:
                begin
                    reconfigure(1'b1, 1'b0, $urandom_range(0, 255), 16, 46);
                    beats = 60;
                end
                5: reconfigure(1'b1, 1'b1, $urandom_range(0, 255), 8,
                               $urandom_range(0, 63));
                default:
                begin
                    reconfigure(1'b1, 1'b1, $urandom_range(0, 255), $urandom_range(0, 31),
                                $urandom_range(30, 63));
                    beats = 240;
                end
            endcase
            repeat (beats) random_beat();
        end
    endtask

    initial
    begin
        int i;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = mpmtr_pkg::OP_LOAD;
        entry_index = '0;
        entry_base_frame = '0;
        entry_mask_frame = '0;
        entry_type = '0;
        entry_valid = 1'b0;
        page_addr = '0;
        cfg_valid = 1'b0;
        cfg_index = mpmtr_pkg::CFG_SUPPORTED;
        cfg_data = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        for (i = 0; i < SLOTS; i++)
        begin
            slot_base[i] = '0;
            slot_mask[i] = '0;
            slot_kind[i] = '0;
            slot_valid[i] = 1'b0;
        end
        reg_supported = 1'b1;
        reg_enabled = 1'b0;
        reg_default = '0;
        reg_range_count = mpmtr_pkg::CNT_W'(8);
        reg_addr_bits = mpmtr_pkg::PAB_W'(46);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_reset_defaults();
        check_range_rules();
        check_register_extremes();
        run_random_traffic();
        drain();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
sv/mpmtr_pkg.sv
sv/mpmtr_cell.sv
sv/mtrr_page_memory_type_resolver.sv
tb/sv/mtrr_page_memory_type_resolver_test.sv
